### hdl/god_pkg.sv
// Package for the glyph outline decoder: shared codes, flag bit positions,
// and the command and status structs between controller and datapath.
// No dependencies.
package god_pkg;

  // Default capacity of the flag and x coordinate stores
  localparam int MaxPointsDef = 64;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_CONTOURS = 2'd0;
  localparam logic [1:0] ERR_POINTS   = 2'd1;
  localparam logic [1:0] ERR_REPEAT   = 2'd2;

  // Bit positions of the packed flag held in the flag store
  localparam int FL_ON     = 0;
  localparam int FL_XSHORT = 1;
  localparam int FL_YSHORT = 2;
  localparam int FL_XSAME  = 3;
  localparam int FL_YSAME  = 4;
  localparam int FlagW     = 5;

  // Repeat bit of a raw flag byte
  localparam int RAW_REPEAT = 3;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_RESTART,
    OP_HDR,
    OP_ENDS,
    OP_ILEN,
    OP_SKIP,
    OP_FLAG,
    OP_FREP,
    OP_REP,
    OP_XSTART,
    OP_XFETCH,
    OP_XSAME,
    OP_XBYTE,
    OP_YSTART,
    OP_YFETCH,
    OP_YSAME,
    OP_YBYTE,
    OP_ERR
  } god_op_e;

  typedef struct packed {
    god_op_e    op;
    logic [1:0] err;
  } god_cmd_t;

  typedef struct packed {
    logic half;        // second byte of a word
    logic hdr_final;   // this byte completes the header
    logic positive;    // contour count is positive
    logic too_many;    // contour count above capacity
    logic ends_last;   // this byte completes the last contour end
    logic total_over;  // point count above capacity
    logic word_zero;   // current word is zero
    logic skip_one;    // last instruction byte
    logic raw_rep;     // flag byte carries repeat
    logic flag_end;    // flag write fills the last point
    logic rep_over;    // repeat count runs past the points
    logic rep_zero;    // no repeats left
    logic cursor_end;  // cursor reached point count
    logic xshort;
    logic xsame;
    logic yshort;
    logic ysame;
    logic out_free;    // output register can take a result
  } god_stat_t;

endpackage

### hdl/god_stream_if.sv
// Valid/ready channel interfaces: glyph byte stream in, decoded results out.
// Depends on nothing.
interface god_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, data_byte, record_start, input ready);
  modport sink   (input valid, data_byte, record_start, output ready);
endinterface

interface god_res_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] box_x_max;
  logic signed [15:0] box_y_max;
  logic        [15:0] number;
  logic               on_curve;
  logic        [1:0]  error_code;
  logic               last;

  modport source (output valid, kind, coord_x, coord_y, box_x_max, box_y_max, number,
                  on_curve, error_code, last, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, box_x_max, box_y_max, number,
                  on_curve, error_code, last, output ready);
endinterface

### hdl/god_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module god_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/god_datapath.sv
// Datapath of the glyph outline decoder: field registers, counters,
// flag and x stores, coordinate accumulators and the output register.
// Depends on god_pkg, god_stream_if and god_ram.
module god_datapath #(
  parameter int MAX_POINTS = god_pkg::MaxPointsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  god_pkg::god_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output god_pkg::god_stat_t stat_o,
  god_res_if.source         res_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = CW + 9;

  logic [7:0]    high_q, high_d;
  logic          half_q, half_d;
  logic [15:0]   fc_q, fc_d;
  logic [15:0]   skip_q, skip_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [7:0]    rep_q, rep_d;
  logic [15:0]   box_q [3];
  logic [15:0]   box_d [3];
  logic [15:0]   run_x_q, run_x_d;
  logic [15:0]   run_y_q, run_y_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q, kind_d;
  logic [15:0]   cx_q, cx_d, cy_q, cy_d, bx_q, bx_d, by_q, by_d, num_q, num_d;
  logic          on_q, on_d, last_q, last_d;
  logic [1:0]    err_q, err_d;
  logic          load;

  logic [15:0]      word;
  logic [FlagW_L-1:0] flag_wr_dummy;
  localparam int FlagW_L = god_pkg::FlagW;
  logic [FlagW_L-1:0] flag_pack, flag_rd, flag_wdata;
  logic [15:0]      x_rd, x_wdata, x_new, y_new;
  logic             flag_we, flag_re, x_we, x_re;
  logic             pt_last, x_done, y_done;
  logic [CW-1:0]    cursor_inc;

  assign word       = {high_q, data_byte_i};
  assign flag_pack  = {data_byte_i[5], data_byte_i[4], data_byte_i[2:0]};
  assign cursor_inc = cursor_q + CW'(1);
  assign pt_last    = cursor_inc == total_q;
  assign flag_wr_dummy = flag_pack;

  // Status toward the controller
  always_comb begin
    stat_o.half       = half_q;
    stat_o.hdr_final  = half_q && (fc_q >= 16'd4);
    stat_o.positive   = (skip_q != 16'd0) && !skip_q[15];
    stat_o.too_many   = skip_q > 16'(MAX_POINTS);
    stat_o.ends_last  = half_q && (fc_q == 16'd1);
    stat_o.total_over = ({1'b0, word} + 17'd1) > 17'(MAX_POINTS);
    stat_o.word_zero  = word == 16'd0;
    stat_o.skip_one   = skip_q == 16'd1;
    stat_o.raw_rep    = data_byte_i[god_pkg::RAW_REPEAT];
    stat_o.flag_end   = {1'b0, cursor_q} + (CW + 1)'(1) >= {1'b0, total_q};
    stat_o.rep_over   = (SW'(cursor_q) + SW'(data_byte_i)) > SW'(total_q);
    stat_o.rep_zero   = rep_q == 8'd0;
    stat_o.cursor_end = cursor_q >= total_q;
    stat_o.xshort     = flag_rd[god_pkg::FL_XSHORT];
    stat_o.xsame      = flag_rd[god_pkg::FL_XSAME];
    stat_o.yshort     = flag_rd[god_pkg::FL_YSHORT];
    stat_o.ysame      = flag_rd[god_pkg::FL_YSAME];
    stat_o.out_free   = !out_valid_q || res_o.ready;
  end

  // Coordinate deltas: short form is a signed byte by the same bit, long form a word
  always_comb begin
    if (flag_rd[god_pkg::FL_XSHORT]) begin
      x_new = flag_rd[god_pkg::FL_XSAME] ? run_x_q + {8'd0, data_byte_i}
                                         : run_x_q - {8'd0, data_byte_i};
    end else begin
      x_new = run_x_q + word;
    end
    if (flag_rd[god_pkg::FL_YSHORT]) begin
      y_new = flag_rd[god_pkg::FL_YSAME] ? run_y_q + {8'd0, data_byte_i}
                                         : run_y_q - {8'd0, data_byte_i};
    end else begin
      y_new = run_y_q + word;
    end
  end
  assign x_done = flag_rd[god_pkg::FL_XSHORT] || half_q;
  assign y_done = flag_rd[god_pkg::FL_YSHORT] || half_q;

  // Store ports
  always_comb begin
    flag_we    = 1'b0;
    flag_wdata = flag_pack;
    flag_re    = 1'b0;
    x_we       = 1'b0;
    x_wdata    = run_x_q;
    x_re       = 1'b0;
    case (cmd_i.op)
      god_pkg::OP_FLAG: flag_we = 1'b1;
      god_pkg::OP_REP: begin
        flag_we    = 1'b1;
        flag_wdata = high_q[FlagW_L-1:0];
      end
      god_pkg::OP_XFETCH: flag_re = 1'b1;
      god_pkg::OP_YFETCH: begin
        flag_re = 1'b1;
        x_re    = 1'b1;
      end
      god_pkg::OP_XSAME: x_we = 1'b1;
      god_pkg::OP_XBYTE: begin
        x_we    = x_done;
        x_wdata = x_new;
      end
      default: ;
    endcase
  end

  god_ram #(.WIDTH(FlagW_L), .DEPTH(MAX_POINTS)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (cursor_q[AW-1:0]),
    .wdata_i (flag_wdata),
    .re_i    (flag_re),
    .raddr_i (cursor_q[AW-1:0]),
    .rdata_o (flag_rd)
  );

  god_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (cursor_q[AW-1:0]),
    .wdata_i (x_wdata),
    .re_i    (x_re),
    .raddr_i (cursor_q[AW-1:0]),
    .rdata_o (x_rd)
  );

  // Field registers and counters
  always_comb begin
    high_d  = high_q;
    half_d  = half_q;
    fc_d    = fc_q;
    skip_d  = skip_q;
    total_d = total_q;
    cursor_d = cursor_q;
    rep_d   = rep_q;
    box_d   = box_q;
    run_x_d = run_x_q;
    run_y_d = run_y_q;
    case (cmd_i.op)
      god_pkg::OP_RESTART: begin
        fc_d   = 16'd0;
        half_d = 1'b1;
        high_d = data_byte_i;
      end
      god_pkg::OP_HDR: begin
        if (!half_q) begin
          high_d = data_byte_i;
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (fc_q == 16'd0) begin
            skip_d = word;
            fc_d   = 16'd1;
          end else if (fc_q < 16'd4) begin
            box_d[fc_q[1:0] - 2'd1] = word;
            fc_d = fc_q + 16'd1;
          end else if (stat_o.positive && !stat_o.too_many) begin
            fc_d = skip_q;
          end
        end
      end
      god_pkg::OP_ENDS: begin
        if (!half_q) begin
          high_d = data_byte_i;
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          fc_d   = fc_q - 16'd1;
          if (fc_q == 16'd1 && !stat_o.total_over) begin
            total_d = CW'(word + 16'd1);
          end
        end
      end
      god_pkg::OP_ILEN: begin
        if (!half_q) begin
          high_d = data_byte_i;
          half_d = 1'b1;
        end else begin
          half_d   = 1'b0;
          skip_d   = word;
          cursor_d = '0;
        end
      end
      god_pkg::OP_SKIP: skip_d = skip_q - 16'd1;
      god_pkg::OP_FLAG: begin
        cursor_d = cursor_inc;
        if (stat_o.raw_rep) begin
          high_d = {{(8 - FlagW_L){1'b0}}, flag_pack};
        end
      end
      god_pkg::OP_FREP: rep_d = data_byte_i;
      god_pkg::OP_REP: begin
        cursor_d = cursor_inc;
        rep_d    = rep_q - 8'd1;
      end
      god_pkg::OP_XSTART: begin
        cursor_d = '0;
        run_x_d  = 16'd0;
        half_d   = 1'b0;
      end
      god_pkg::OP_XSAME: cursor_d = cursor_inc;
      god_pkg::OP_XBYTE: begin
        if (x_done) begin
          run_x_d  = x_new;
          cursor_d = cursor_inc;
          half_d   = 1'b0;
        end else begin
          high_d = data_byte_i;
          half_d = 1'b1;
        end
      end
      god_pkg::OP_YSTART: begin
        cursor_d = '0;
        run_y_d  = 16'd0;
        half_d   = 1'b0;
      end
      god_pkg::OP_YSAME: cursor_d = cursor_inc;
      god_pkg::OP_YBYTE: begin
        if (y_done) begin
          run_y_d  = y_new;
          cursor_d = cursor_inc;
          half_d   = 1'b0;
        end else begin
          high_d = data_byte_i;
          half_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result load into the output register
  always_comb begin
    load   = 1'b0;
    kind_d = kind_q;
    cx_d   = 16'd0;
    cy_d   = 16'd0;
    bx_d   = 16'd0;
    by_d   = 16'd0;
    num_d  = 16'd0;
    on_d   = 1'b0;
    err_d  = 2'd0;
    last_d = 1'b0;
    case (cmd_i.op)
      god_pkg::OP_HDR: begin
        load   = stat_o.hdr_final;
        kind_d = god_pkg::KIND_HEADER;
        cx_d   = box_q[0];
        cy_d   = box_q[1];
        bx_d   = box_q[2];
        by_d   = word;
        num_d  = stat_o.positive ? skip_q : 16'd0;
        last_d = !stat_o.positive;
      end
      god_pkg::OP_ENDS: begin
        load   = half_q;
        kind_d = god_pkg::KIND_END;
        num_d  = word;
      end
      god_pkg::OP_YSAME, god_pkg::OP_YBYTE: begin
        load   = (cmd_i.op == god_pkg::OP_YSAME) || y_done;
        kind_d = god_pkg::KIND_POINT;
        cx_d   = x_rd;
        cy_d   = (cmd_i.op == god_pkg::OP_YSAME) ? run_y_q : y_new;
        num_d  = 16'(cursor_q);
        on_d   = flag_rd[god_pkg::FL_ON];
        last_d = pt_last;
      end
      god_pkg::OP_ERR: begin
        load   = 1'b1;
        kind_d = god_pkg::KIND_ERROR;
        err_d  = cmd_i.err;
        last_d = 1'b1;
      end
      default: ;
    endcase
    out_valid_d = load || (out_valid_q && !res_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q      <= 8'd0;
      half_q      <= 1'b0;
      fc_q        <= 16'd0;
      skip_q      <= 16'd0;
      total_q     <= '0;
      cursor_q    <= '0;
      rep_q       <= 8'd0;
      box_q       <= '{default: 16'd0};
      run_x_q     <= 16'd0;
      run_y_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      high_q      <= high_d;
      half_q      <= half_d;
      fc_q        <= fc_d;
      skip_q      <= skip_d;
      total_q     <= total_d;
      cursor_q    <= cursor_d;
      rep_q       <= rep_d;
      box_q       <= box_d;
      run_x_q     <= run_x_d;
      run_y_q     <= run_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      num_q  <= num_d;
      on_q   <= on_d;
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.coord_x    = $signed(cx_q);
  assign res_o.coord_y    = $signed(cy_q);
  assign res_o.box_x_max  = $signed(bx_q);
  assign res_o.box_y_max  = $signed(by_q);
  assign res_o.number     = num_q;
  assign res_o.on_curve   = on_q;
  assign res_o.error_code = err_q;
  assign res_o.last       = last_q;

endmodule

### hdl/god_ctrl.sv
// Controller of the glyph outline decoder: sequences record sections and
// issues one datapath operation per cycle. Depends on god_pkg.
module god_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_start_i,
  output logic               in_ready_o,
  input  god_pkg::god_stat_t stat_i,
  output god_pkg::god_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HDR   = 5'd1;
  localparam logic [4:0] S_ENDS  = 5'd2;
  localparam logic [4:0] S_ILEN  = 5'd3;
  localparam logic [4:0] S_SKIP  = 5'd4;
  localparam logic [4:0] S_FLAG  = 5'd5;
  localparam logic [4:0] S_FREP  = 5'd6;
  localparam logic [4:0] S_REP   = 5'd7;
  localparam logic [4:0] S_XINIT = 5'd8;
  localparam logic [4:0] S_XCHK  = 5'd9;
  localparam logic [4:0] S_XDEC  = 5'd10;
  localparam logic [4:0] S_XBYTE = 5'd11;
  localparam logic [4:0] S_YINIT = 5'd12;
  localparam logic [4:0] S_YCHK  = 5'd13;
  localparam logic [4:0] S_YDEC  = 5'd14;
  localparam logic [4:0] S_YBYTE = 5'd15;
  localparam logic [4:0] S_ERR   = 5'd16;

  logic [4:0] state_q, state_d;
  logic [1:0] err_q, err_d;
  logic       wait_byte, accept;

  // States that take a byte; of them, S_HDR, S_ENDS and S_YBYTE may put out a result
  always_comb begin
    unique case (state_q)
      S_IDLE, S_HDR, S_ENDS, S_ILEN, S_SKIP, S_FLAG, S_FREP, S_XBYTE, S_YBYTE:
        wait_byte = 1'b1;
      default: wait_byte = 1'b0;
    endcase
  end
  assign in_ready_o = wait_byte && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    cmd_o.op   = god_pkg::OP_NONE;
    cmd_o.err  = err_q;
    if (accept && in_start_i) begin
      // a new record drops whatever was in progress
      cmd_o.op = god_pkg::OP_RESTART;
      state_d  = S_HDR;
    end else begin
      unique case (state_q)
        S_IDLE: ;
        S_HDR: if (accept) begin
          cmd_o.op = god_pkg::OP_HDR;
          if (stat_i.hdr_final) begin
            if (!stat_i.positive) begin
              state_d = S_IDLE;
            end else if (stat_i.too_many) begin
              err_d   = god_pkg::ERR_CONTOURS;
              state_d = S_ERR;
            end else begin
              state_d = S_ENDS;
            end
          end
        end
        S_ENDS: if (accept) begin
          cmd_o.op = god_pkg::OP_ENDS;
          if (stat_i.ends_last) begin
            if (stat_i.total_over) begin
              err_d   = god_pkg::ERR_POINTS;
              state_d = S_ERR;
            end else begin
              state_d = S_ILEN;
            end
          end
        end
        S_ILEN: if (accept) begin
          cmd_o.op = god_pkg::OP_ILEN;
          if (stat_i.half) begin
            state_d = stat_i.word_zero ? S_FLAG : S_SKIP;
          end
        end
        S_SKIP: if (accept) begin
          cmd_o.op = god_pkg::OP_SKIP;
          if (stat_i.skip_one) state_d = S_FLAG;
        end
        S_FLAG: if (accept) begin
          cmd_o.op = god_pkg::OP_FLAG;
          if (stat_i.raw_rep) begin
            state_d = S_FREP;
          end else if (stat_i.flag_end) begin
            state_d = S_XINIT;
          end
        end
        S_FREP: if (accept) begin
          cmd_o.op = god_pkg::OP_FREP;
          if (stat_i.rep_over) begin
            err_d   = god_pkg::ERR_REPEAT;
            state_d = S_ERR;
          end else begin
            state_d = S_REP;
          end
        end
        // one repeated flag written per cycle
        S_REP: begin
          if (stat_i.rep_zero) begin
            state_d = stat_i.cursor_end ? S_XINIT : S_FLAG;
          end else begin
            cmd_o.op = god_pkg::OP_REP;
          end
        end
        S_XINIT: begin
          cmd_o.op = god_pkg::OP_XSTART;
          state_d  = S_XCHK;
        end
        S_XCHK: begin
          if (stat_i.cursor_end) begin
            state_d = S_YINIT;
          end else begin
            cmd_o.op = god_pkg::OP_XFETCH;
            state_d  = S_XDEC;
          end
        end
        S_XDEC: begin
          if (!stat_i.xshort && stat_i.xsame) begin
            cmd_o.op = god_pkg::OP_XSAME;
            state_d  = S_XCHK;
          end else begin
            state_d = S_XBYTE;
          end
        end
        S_XBYTE: if (accept) begin
          cmd_o.op = god_pkg::OP_XBYTE;
          if (stat_i.xshort || stat_i.half) state_d = S_XCHK;
        end
        S_YINIT: begin
          cmd_o.op = god_pkg::OP_YSTART;
          state_d  = S_YCHK;
        end
        S_YCHK: begin
          if (stat_i.cursor_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = god_pkg::OP_YFETCH;
            state_d  = S_YDEC;
          end
        end
        S_YDEC: begin
          if (!stat_i.yshort && stat_i.ysame) begin
            if (stat_i.out_free) begin
              cmd_o.op = god_pkg::OP_YSAME;
              state_d  = S_YCHK;
            end
          end else begin
            state_d = S_YBYTE;
          end
        end
        S_YBYTE: if (accept) begin
          cmd_o.op = god_pkg::OP_YBYTE;
          if (stat_i.yshort || stat_i.half) state_d = S_YCHK;
        end
        S_ERR: begin
          if (stat_i.out_free) begin
            cmd_o.op = god_pkg::OP_ERR;
            state_d  = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= god_pkg::ERR_CONTOURS;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

### hdl/glyph_outline_decoder.sv
// Simple outline glyph decoder. Each x or y point step runs a check, a registered
// store read and, unless the coordinate repeats, a byte. Results leave through an
// output register; the byte port stalls while that register holds a result not yet
// taken, and in states that take no byte, such as flag repeat expansion. Reset clears
// the sequencer and all counters at once; the stores are not cleared.
module glyph_outline_decoder #(
  parameter int MAX_POINTS = god_pkg::MaxPointsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  god_byte_if.sink  byte_i,
  god_res_if.source res_o
);

  god_pkg::god_cmd_t  cmd;
  god_pkg::god_stat_t stat;
  logic               in_ready;

  // Sequencer
  god_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_start_i (byte_i.record_start),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign byte_i.ready = in_ready;

  // Registers, stores and output stage
  god_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (byte_i.data_byte),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule
